[rtl/tdq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_pkg
// Shared types and constants for the two-stack deque: item and result
// structs, operation codes, the memory control and read dispatch structs.
// ----------------------------------------------------------------------------
package tdq_pkg;

  // Fixed field widths of the transfer payloads
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned INDEX_W    = 9;
  localparam int unsigned SIZE_W     = 10;

  // Default entries per stack
  localparam int unsigned SIDE_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_READ_AT    = 2'd2,
    OP_WRITE_AT   = 2'd3
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic [DATA_WIDTH-1:0] value;
    logic [INDEX_W-1:0]    index;
  } item_t;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_value;
    logic                  error;
    logic [SIZE_W-1:0]     size;
    logic                  empty_res;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;
  } result_t;

  // Per-memory access strobes
  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

  // Read dispatch info from the address map to the handshake logic
  typedef struct packed {
    logic rd_hit;
    logic rd_back;
  } rd_ctl_t;

endpackage

[rtl/tdq_stack_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_stack_mem
// Single-port synchronous stack storage with a registered read.
// ----------------------------------------------------------------------------
module tdq_stack_mem #(
  parameter int unsigned DEPTH = tdq_pkg::SIDE_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  tdq_pkg::mem_ctl_t               ctl_i,
  input  logic [$clog2(DEPTH)-1:0]        addr_i,
  input  logic [tdq_pkg::DATA_WIDTH-1:0]  wdata_i,
  output logic [tdq_pkg::DATA_WIDTH-1:0]  rdata_o
);
  import tdq_pkg::*;

  logic [DATA_WIDTH-1:0] mem_q [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  // Write and registered read share the address
  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tdq_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdq_core
// Stack counters, end-element shadow registers and logical index mapping.
// Drives the two stack memories and builds the status part of a result.
// ----------------------------------------------------------------------------
module tdq_core #(
  parameter int unsigned SIDE_DEPTH = tdq_pkg::SIDE_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                acc_i,
  input  tdq_pkg::item_t                      item_i,
  output tdq_pkg::mem_ctl_t                   f_ctl_o,
  output logic [$clog2(SIDE_DEPTH)-1:0]       f_addr_o,
  output tdq_pkg::mem_ctl_t                   b_ctl_o,
  output logic [$clog2(SIDE_DEPTH)-1:0]       b_addr_o,
  output tdq_pkg::rd_ctl_t                    rd_ctl_o,
  output tdq_pkg::result_t                    status_o
);
  import tdq_pkg::*;

  localparam int unsigned AW = $clog2(SIDE_DEPTH);
  localparam int unsigned CW = $clog2(SIDE_DEPTH + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned PW = (SW > INDEX_W) ? SW : INDEX_W;

  logic [CW-1:0]         fc_q, fc_d, bc_q, bc_d;
  logic [DATA_WIDTH-1:0] ftop_q, ftop_d, fbot_q, fbot_d;
  logic [DATA_WIDTH-1:0] btop_q, btop_d, bbot_q, bbot_d;
  logic [PW-1:0]         pos, fc_x, bc_x, tot_x, f_off, b_off;
  logic [SW-1:0]         tot_d;
  logic                  hit, in_front, f_full, b_full, err;

  // Logical index to stack entry
  always_comb begin
    pos      = PW'(item_i.index);
    fc_x     = PW'(fc_q);
    bc_x     = PW'(bc_q);
    tot_x    = fc_x + bc_x;
    hit      = pos < tot_x;
    in_front = pos < fc_x;
    f_off    = fc_x - pos - PW'(1);
    b_off    = pos - fc_x;
    f_full   = fc_q == CW'(SIDE_DEPTH);
    b_full   = bc_q == CW'(SIDE_DEPTH);
  end

  // Operation decode and next state
  always_comb begin
    fc_d     = fc_q;
    bc_d     = bc_q;
    ftop_d   = ftop_q;
    fbot_d   = fbot_q;
    btop_d   = btop_q;
    bbot_d   = bbot_q;
    f_ctl_o  = '0;
    b_ctl_o  = '0;
    f_addr_o = f_off[AW-1:0];
    b_addr_o = b_off[AW-1:0];
    rd_ctl_o = '0;
    err      = 1'b0;
    if (acc_i) begin
      unique case (item_i.op)
        OP_PUSH_FRONT: begin
          if (f_full) begin
            err = 1'b1;
          end else begin
            f_ctl_o.we = 1'b1;
            f_addr_o   = fc_q[AW-1:0];
            fc_d       = fc_q + CW'(1);
            ftop_d     = item_i.value;
            if (fc_q == '0) begin
              fbot_d = item_i.value;
            end
          end
        end
        OP_PUSH_BACK: begin
          if (b_full) begin
            err = 1'b1;
          end else begin
            b_ctl_o.we = 1'b1;
            b_addr_o   = bc_q[AW-1:0];
            bc_d       = bc_q + CW'(1);
            btop_d     = item_i.value;
            if (bc_q == '0) begin
              bbot_d = item_i.value;
            end
          end
        end
        OP_READ_AT: begin
          if (!hit) begin
            err = 1'b1;
          end else begin
            rd_ctl_o.rd_hit  = 1'b1;
            rd_ctl_o.rd_back = !in_front;
            f_ctl_o.re       = in_front;
            b_ctl_o.re       = !in_front;
          end
        end
        OP_WRITE_AT: begin
          if (!hit) begin
            err = 1'b1;
          end else if (in_front) begin
            // Keep the end shadows coherent with the stored entry
            f_ctl_o.we = 1'b1;
            if (f_off == fc_x - PW'(1)) ftop_d = item_i.value;
            if (f_off == '0)            fbot_d = item_i.value;
          end else begin
            b_ctl_o.we = 1'b1;
            if (b_off == bc_x - PW'(1)) btop_d = item_i.value;
            if (b_off == '0)            bbot_d = item_i.value;
          end
        end
        default: err = 1'b0;
      endcase
    end
  end

  // Status after the step
  always_comb begin
    tot_d                = SW'(fc_d) + SW'(bc_d);
    status_o.read_value  = '0;
    status_o.error       = err;
    status_o.size        = SIZE_W'(tot_d);
    status_o.empty_res   = tot_d == '0;
    status_o.front_value = '0;
    status_o.back_value  = '0;
    if (tot_d != '0) begin
      status_o.front_value = (fc_d != '0) ? ftop_d : bbot_d;
      status_o.back_value  = (bc_d != '0) ? btop_d : fbot_d;
    end
  end

  // Counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
      bc_q <= '0;
    end else begin
      fc_q <= fc_d;
      bc_q <= bc_d;
    end
  end

  // End-element shadows, only read while the matching count is nonzero
  always_ff @(posedge clk_i) begin
    ftop_q <= ftop_d;
    fbot_q <= fbot_d;
    btop_q <= btop_d;
    bbot_q <= bbot_d;
  end

endmodule

[rtl/two_stack_deque.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stack_deque
// Double-ended store built from two stacks held in synchronous memories.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one operation
//   per transfer: push front, push back, read at index, write at index.
//   Output channel (out_valid_o / out_stall_i / out_item_o) returns exactly
//   one result per operation, in order, held in an output register.
//   Pushes, writes and out-of-range reads: result is registered at the
//   accepting edge, visible the next cycle; one item per cycle unless stalled.
//   In-range reads: the result is loaded from the registered read of the
//   stack memory; the input stalls during the memory read cycle.
//   End values come from shadow registers and size from the counters, so
//   no extra memory access is needed for them.
//   A receiver stall holds the result; a new item is accepted only while
//   the output register is empty or being drained in the same cycle.
//   Reset clears both stack counts; memory contents are not cleared and
//   need no clearing pass, since only written entries are ever read.
// ----------------------------------------------------------------------------
module two_stack_deque #(
  parameter int unsigned SIDE_DEPTH = tdq_pkg::SIDE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tdq_pkg::item_t   in_item_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tdq_pkg::result_t out_item_o
);
  import tdq_pkg::*;

  localparam int unsigned AW = $clog2(SIDE_DEPTH);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                  state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q, out_d;
  logic                  sel_back_q, sel_back_d;
  logic                  in_acc;
  mem_ctl_t              f_ctl, b_ctl;
  logic [AW-1:0]         f_addr, b_addr;
  logic [DATA_WIDTH-1:0] f_rdata, b_rdata;
  rd_ctl_t               rd_ctl;
  result_t               status;

  assign in_stall_o = (state_q == ST_READ) || (out_valid_q && out_stall_i);
  assign in_acc     = in_valid_i && !in_stall_o;

  tdq_core #(
    .SIDE_DEPTH (SIDE_DEPTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (in_acc),
    .item_i   (in_item_i),
    .f_ctl_o  (f_ctl),
    .f_addr_o (f_addr),
    .b_ctl_o  (b_ctl),
    .b_addr_o (b_addr),
    .rd_ctl_o (rd_ctl),
    .status_o (status)
  );

  tdq_stack_mem #(
    .DEPTH (SIDE_DEPTH)
  ) u_front_mem (
    .clk_i   (clk_i),
    .ctl_i   (f_ctl),
    .addr_i  (f_addr),
    .wdata_i (in_item_i.value),
    .rdata_o (f_rdata)
  );

  tdq_stack_mem #(
    .DEPTH (SIDE_DEPTH)
  ) u_back_mem (
    .clk_i   (clk_i),
    .ctl_i   (b_ctl),
    .addr_i  (b_addr),
    .wdata_i (in_item_i.value),
    .rdata_o (b_rdata)
  );

  // Sequencing and output register load
  always_comb begin
    state_d     = state_q;
    sel_back_d  = sel_back_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (rd_ctl.rd_hit) begin
            state_d    = ST_READ;
            sel_back_d = rd_ctl.rd_back;
          end else begin
            out_d       = status;
            out_valid_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        // Memory data is valid this cycle
        out_d            = status;
        out_d.read_value = sel_back_q ? b_rdata : f_rdata;
        out_valid_d      = 1'b1;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    sel_back_q <= sel_back_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Memory read cycle is a single cycle
  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |=> state_q == ST_IDLE)
    else $error("read state held longer than one cycle");

  // Output register must be free when read data arrives
  a_read_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> !out_valid_q)
    else $error("output register busy during memory read");

  // An in-range read enters the read state
  a_read_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && rd_ctl.rd_hit |=> state_q == ST_READ)
    else $error("in-range read not dispatched");

  // Every other accepted item yields a result at once
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !rd_ctl.rd_hit |=> out_valid_q)
    else $error("result missing after accepted item");

endmodule
